>>> rtl/ohl_pkg.sv
// ohl_pkg: shared types and op codes for the ordered handle list
// no dependencies
package ohl_pkg;

	localparam int OP_BITS = 4;

	typedef enum logic [3:0] {
		OP_ADD_HEAD   = 4'd0,
		OP_ADD_TAIL   = 4'd1,
		OP_REM_VALUE  = 4'd2,
		OP_REM_AT     = 4'd3,
		OP_INDEX_OF   = 4'd4,
		OP_GET_AT     = 4'd5,
		OP_CUR_RESET  = 4'd6,
		OP_CUR_NEXT   = 4'd7,
		OP_TO_HEAD    = 4'd8,
		OP_TO_TAIL    = 4'd9,
		OP_COUNT      = 4'd10
	} op_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] value;
		logic [3:0]  index;
	} in_beat_t;

	typedef struct packed {
		logic        found;
		logic [15:0] data;
		logic [3:0]  position;
		logic [4:0]  count;
		logic        full_error;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} state_t;

	// per-cell shift command
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_RIGHT,
		SH_LEFT,
		SH_LOAD
	} shift_t;

	typedef struct packed {
		shift_t sh;
	} cell_ctl_t;

endpackage

>>> rtl/ohl_cell.sv
// ohl_cell: one list slot holding a handle, compares against the key and
// shifts toward either neighbor; depends on ohl_pkg
module ohl_cell import ohl_pkg::*; #(
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic [HANDLE_BITS-1:0] left_data,
	input  logic [HANDLE_BITS-1:0] right_data,
	input  logic [HANDLE_BITS-1:0] load_data,
	input  logic [HANDLE_BITS-1:0] key,
	output logic [HANDLE_BITS-1:0] data,
	output logic                   match
);

	logic [HANDLE_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.sh)
			SH_RIGHT: data_q <= left_data;
			SH_LEFT:  data_q <= right_data;
			SH_LOAD:  data_q <= load_data;
			default:  data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == key);

endmodule

>>> rtl/ordered_handle_list.sv
// Ordered handle list: a dense row of DEPTH cells with position 0 at the head. A beat is
// accepted only while the block is idle. It then enters the execute state: every cell compares
// its handle against the operand in parallel, and at the end of that same cycle the row shifts
// or loads and the result register captures the outcome. The result beat is offered in the
// cycle after the execute state. A move to head or tail that must first remove the value stays
// in execute after the removal and then adds the value. After the result beat is taken, the
// block returns to idle before the next acceptance, so a new beat is not taken before the last
// result has been taken. No clearing pass after reset.
// depends on ohl_pkg, ohl_cell
module ordered_handle_list import ohl_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [OP_BITS-1:0]     op_q;
	logic [HANDLE_BITS-1:0] key_q;
	logic [3:0]             idx_q;
	logic                   phase_q;
	logic [CW-1:0]          cnt_q;
	logic [PW-1:0]          cur_q;
	logic                   cnull_q;
	out_beat_t              res_q;

	cell_ctl_t              ctl   [DEPTH];
	logic [HANDLE_BITS-1:0] cdata [DEPTH];
	logic [DEPTH-1:0]       cmatch;

	logic [HANDLE_BITS-1:0] cmp_key;
	logic [HANDLE_BITS-1:0] load_val;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			ohl_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
				.clk       (clk),
				.ctl       (ctl[g]),
				.left_data ((g == 0) ? load_val : cdata[(g == 0) ? 0 : g - 1]),
				.right_data(cdata[(g == DEPTH - 1) ? g : g + 1]),
				.load_data (load_val),
				.key       (cmp_key),
				.data      (cdata[g]),
				.match     (cmatch[g])
			);
		end
	endgenerate

	// index selected by the beat, in range of the list
	logic          idx_ok;
	logic [PW-1:0] idx_p;
	assign idx_ok = ({{(CW > 4 ? CW - 4 : 0){1'b0}}, idx_q} < {{(4 > CW ? 4 - CW : 0){1'b0}}, cnt_q})
		&& (32'(idx_q) < DEPTH);
	assign idx_p  = PW'(idx_q);

	// remove-at uses the stored handle as key
	assign cmp_key  = (op_q == OP_REM_AT) ? cdata[idx_p] : key_q;
	assign load_val = key_q;

	// first live match
	logic          hit;
	logic [PW-1:0] hit_p;
	always_comb begin
		hit   = 1'b0;
		hit_p = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cmatch[i] && (CW'(i) < cnt_q)) begin
				hit   = 1'b1;
				hit_p = PW'(i);
			end
		end
		if (cmp_key == '0) hit = 1'b0;
	end

	logic [PW-1:0] tail_p;
	assign tail_p = PW'(cnt_q - CW'(1));

	logic full;
	assign full = (cnt_q == CW'(DEPTH));

	// execute decode
	logic          do_add, add_tail, do_rem, done;
	logic          r_found, r_ferr;
	logic [HANDLE_BITS-1:0] r_data;
	logic [3:0]    r_pos;

	always_comb begin
		do_add   = 1'b0;
		add_tail = 1'b0;
		do_rem   = 1'b0;
		done     = 1'b1;
		r_found  = 1'b0;
		r_ferr   = 1'b0;
		r_data   = '0;
		r_pos    = '0;
		unique case (op_q)
			OP_ADD_HEAD, OP_ADD_TAIL: begin
				add_tail = (op_q == OP_ADD_TAIL);
				do_add   = !full;
				r_ferr   = full;
			end
			OP_REM_VALUE: begin
				do_rem  = hit;
				r_found = hit;
			end
			OP_REM_AT: begin
				do_rem  = idx_ok && hit;
				r_found = idx_ok && hit;
			end
			OP_INDEX_OF: begin
				r_found = hit;
				r_pos   = hit ? 4'(hit_p) : 4'd0;
			end
			OP_GET_AT: begin
				r_found = idx_ok;
				r_data  = idx_ok ? 16'(cdata[idx_p]) : 16'd0;
			end
			OP_CUR_NEXT: begin
				r_found = !cnull_q && (CW'(cur_q) < cnt_q);
				r_data  = r_found ? 16'(cdata[cur_q]) : 16'd0;
			end
			OP_TO_HEAD, OP_TO_TAIL: begin
				add_tail = (op_q == OP_TO_TAIL);
				if (cnt_q == '0) begin
					do_add = 1'b1;
				end else if (!phase_q) begin
					if (cdata[(op_q == OP_TO_HEAD) ? '0 : tail_p] != key_q) begin
						if (hit) begin
							do_rem = 1'b1;
							done   = 1'b0;
						end else begin
							do_add = !full;
							r_ferr = full;
						end
					end
				end else begin
					do_add = !full;
					r_ferr = full;
				end
			end
			default: ;
		endcase
		if (state_q != ST_EXEC) begin
			do_add = 1'b0;
			do_rem = 1'b0;
		end
	end

	// cell shift commands
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].sh = SH_HOLD;
			if (do_add) begin
				if (add_tail) begin
					if (CW'(i) == cnt_q) ctl[i].sh = SH_LOAD;
				end else if (CW'(i) <= cnt_q) begin
					ctl[i].sh = SH_RIGHT;
				end
			end else if (do_rem) begin
				if (PW'(i) >= hit_p && (CW'(i) + CW'(1) < cnt_q)) ctl[i].sh = SH_LEFT;
			end
		end
	end

	// count and cursor updates
	logic [CW-1:0] cnt_d;
	logic [PW-1:0] cur_d;
	logic          cnull_d;
	always_comb begin
		cnt_d   = cnt_q;
		cur_d   = cur_q;
		cnull_d = cnull_q;
		if (state_q == ST_EXEC) begin
			if (do_add) begin
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == '0) begin
					cur_d   = '0;
					cnull_d = 1'b0;
				end else if (!add_tail && !cnull_q) begin
					cur_d = cur_q + PW'(1);
				end
			end else if (do_rem) begin
				cnt_d = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					cnull_d = 1'b1;
					cur_d   = '0;
				end else if (!cnull_q) begin
					if (cur_q == hit_p) begin
						if (hit_p != '0) cur_d = hit_p - PW'(1);
					end else if (cur_q > hit_p) begin
						cur_d = cur_q - PW'(1);
					end
				end
			end else if (op_q == OP_CUR_RESET) begin
				cur_d   = '0;
				cnull_d = (cnt_q == '0);
			end else if (op_q == OP_CUR_NEXT && r_found) begin
				if (CW'(cur_q) + CW'(1) >= cnt_q) begin
					cnull_d = 1'b1;
					cur_d   = '0;
				end else begin
					cur_d = cur_q + PW'(1);
				end
			end
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: if (done) state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cur_q   <= '0;
			cnull_q <= 1'b1;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			cur_q   <= cur_d;
			cnull_q <= cnull_d;
			if (state_q == ST_EXEC) phase_q <= !done;
			else phase_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_data.op;
			key_q <= HANDLE_BITS'(in_data.value);
			idx_q <= in_data.index;
		end
		if (state_q == ST_EXEC && done) begin
			res_q.found      <= r_found;
			res_q.data       <= r_data;
			res_q.position   <= r_pos;
			res_q.count      <= 5'(cnt_d);
			res_q.full_error <= r_ferr;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("count above depth");
	a_cur_live: assert property (@(posedge clk) disable iff (!arst_n)
		!cnull_q |-> (CW'(cur_q) < cnt_q)) else $error("cursor past tail");
	a_empty_null: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> cnull_q) else $error("cursor live on empty list");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC) |=> $stable(cnt_q)) else $error("count moved outside execute");

endmodule
